FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the radar report frame parser.
// No dependencies; defining SYNTH turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RRFP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RRFP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define RRFP_ASSERT(lbl, cond, msg)
`define RRFP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

FILE: src/rrfp_pkg.sv
// Shared types, constants and byte patterns of the radar report frame parser.
// No dependencies.
package rrfp_pkg;

  localparam int FRAME_LIMIT_DEF  = 128;
  localparam int REPORT_BYTES_DEF = 35;
  localparam int GATE_COUNT_DEF   = 16;

  localparam logic [7:0] HDR_B0  = 8'hF4;
  localparam logic [7:0] HDR_B1  = 8'hF3;
  localparam logic [7:0] HDR_B2  = 8'hF2;
  localparam logic [7:0] HDR_B3  = 8'hF1;
  localparam logic [7:0] TAIL_B0 = 8'hF8;
  localparam logic [7:0] TAIL_B1 = 8'hF7;
  localparam logic [7:0] TAIL_B2 = 8'hF6;
  localparam logic [7:0] TAIL_B3 = 8'hF5;

  // One report frame handed from the parser to the readout
  typedef struct packed {
    logic        bank;
    logic        present;
    logic [15:0] distance;
  } frame_rec_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd0:    val = HDR_B0;
      2'd1:    val = HDR_B1;
      2'd2:    val = HDR_B2;
      default: val = HDR_B3;
    endcase
    return val;
  endfunction

  function automatic logic [7:0] tail_byte(input logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd0:    val = TAIL_B0;
      2'd1:    val = TAIL_B1;
      2'd2:    val = TAIL_B2;
      default: val = TAIL_B3;
    endcase
    return val;
  endfunction

endpackage

FILE: src/rrfp_ram.sv
// Generic RAM: one write port, two read ports with registered, enabled read data.
// No dependencies.
module rrfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 70,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: src/rrfp_front.sv
// Byte parser: header hunt, length, payload store writes, trailer check.
// Depends on rrfp_pkg; writes payload into one of two banks of the RAM.
module rrfp_front #(
  parameter int FRAME_LIMIT  = rrfp_pkg::FRAME_LIMIT_DEF,
  parameter int REPORT_BYTES = rrfp_pkg::REPORT_BYTES_DEF,
  localparam int AW = $clog2(2 * REPORT_BYTES),
  localparam int PW = $clog2(FRAME_LIMIT)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [7:0]           wr_data,
  output logic                 push,
  output rrfp_pkg::frame_rec_t push_rec,
  input  logic                 free_en,
  input  logic                 free_bank,
  output logic [1:0]           busy
);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   len_r, len_nxt;
  logic          tok_r, tok_nxt;
  logic          present_r, present_nxt;
  logic [15:0]   dist_r, dist_nxt;
  logic          wr_bank_r, wr_bank_nxt;
  logic [1:0]    busy_r, busy_nxt;

  logic [16:0]   idx, len_x, p_off, t_off, len_new;
  logic          accept, tok_after;
  logic [AW-1:0] bank_base;

  assign in_ready  = !busy_r[wr_bank_r];
  assign accept    = in_valid && in_ready;
  assign busy      = busy_r;
  assign idx       = 17'(pos_r);
  assign len_x     = 17'(len_r);
  assign p_off     = idx - 17'd6;
  assign t_off     = idx - 17'd6 - len_x;
  assign len_new   = {1'b0, in_byte, len_r[7:0]};
  assign bank_base = wr_bank_r ? AW'(REPORT_BYTES) : '0;

  assign push_rec.bank     = wr_bank_r;
  assign push_rec.present  = present_r;
  assign push_rec.distance = dist_r;

  always_comb begin
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    tok_nxt     = tok_r;
    present_nxt = present_r;
    dist_nxt    = dist_r;
    wr_bank_nxt = wr_bank_r;
    busy_nxt    = busy_r;
    wr_en       = 1'b0;
    wr_addr     = bank_base + AW'(p_off);
    wr_data     = in_byte;
    push        = 1'b0;
    tok_after   = tok_r;

    if (accept) begin
      if (idx < 17'd4) begin
        if (in_byte != rrfp_pkg::hdr_byte(pos_r[1:0])) begin
          // a second-byte miss on the first header byte keeps that byte
          pos_nxt = (pos_r == PW'(1) && in_byte == rrfp_pkg::HDR_B0) ? PW'(1) : '0;
          tok_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + PW'(1);
        end
      end else begin
        pos_nxt = pos_r + PW'(1);
        if (idx == 17'd4) begin
          len_nxt = {8'h00, in_byte};
        end else if (idx == 17'd5) begin
          len_nxt = {in_byte, len_r[7:0]};
          if (17'd10 + len_new > 17'(FRAME_LIMIT)) begin
            pos_nxt = '0;
            tok_nxt = 1'b1;
          end
        end else begin
          if (idx < 17'd6 + len_x) begin
            if (p_off < 17'(REPORT_BYTES)) begin
              wr_en = 1'b1;
            end
            if (p_off == 17'd0) begin
              present_nxt = (in_byte != 8'h00);
            end
            if (p_off == 17'd1) begin
              dist_nxt[7:0] = in_byte;
            end
            if (p_off == 17'd2) begin
              dist_nxt[15:8] = in_byte;
            end
          end else begin
            tok_after = tok_r && (in_byte == rrfp_pkg::tail_byte(t_off[1:0]));
          end
          tok_nxt = tok_after;
          if (idx + 17'd1 == 17'd10 + len_x) begin
            pos_nxt = '0;
            tok_nxt = 1'b1;
            if (tok_after && len_r == 16'(REPORT_BYTES)) begin
              // hand the bank to the readout and flip to the other one
              push                = 1'b1;
              busy_nxt[wr_bank_r] = 1'b1;
              wr_bank_nxt         = !wr_bank_r;
            end
          end
        end
      end
    end

    if (free_en) begin
      busy_nxt[free_bank] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      len_r     <= '0;
      tok_r     <= 1'b1;
      wr_bank_r <= 1'b0;
      busy_r    <= '0;
    end else begin
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      tok_r     <= tok_nxt;
      wr_bank_r <= wr_bank_nxt;
      busy_r    <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    present_r <= present_nxt;
    dist_r    <= dist_nxt;
  end

endmodule

FILE: src/rrfp_queue.sv
// Two-entry queue of finished report frames between parser and readout.
// Depends on rrfp_pkg for the frame record type.
module rrfp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rrfp_pkg::frame_rec_t push_rec,
  input  logic                 pop,
  output logic                 head_valid,
  output rrfp_pkg::frame_rec_t head_rec,
  output logic [1:0]           count
);

  rrfp_pkg::frame_rec_t slot_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           count_r, count_nxt;
  logic                 do_pop;

  assign head_valid = (count_r != 2'd0);
  assign head_rec   = slot_r[rd_ptr_r];
  assign count      = count_r;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

FILE: src/rrfp_back.sv
// Gate readout: reads two energy bytes per gate from the RAM and drives results.
// Depends on rrfp_pkg; a one-deep stage runs beside the RAM read, then the output register.
module rrfp_back #(
  parameter int REPORT_BYTES = rrfp_pkg::REPORT_BYTES_DEF,
  parameter int GATE_COUNT   = rrfp_pkg::GATE_COUNT_DEF,
  localparam int AW = $clog2(2 * REPORT_BYTES),
  localparam int GW = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  rrfp_pkg::frame_rec_t head_rec,
  output logic                 pop,
  output logic                 free_en,
  output logic                 free_bank,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr_lo,
  output logic [AW-1:0]        rd_addr_hi,
  input  logic [7:0]           rd_data_lo,
  input  logic [7:0]           rd_data_hi,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_present,
  output logic [15:0]          out_distance,
  output logic [3:0]           out_gate_index,
  output logic [15:0]          out_gate_energy,
  output logic                 out_last
);

  logic                 active_r, active_nxt;
  logic [GW-1:0]        gate_r, gate_nxt;
  rrfp_pkg::frame_rec_t cur_r;

  logic                 s1_valid_r, s1_valid_nxt;
  logic [GW-1:0]        s1_gate_r;
  logic                 s1_last_r, s1_zlo_r, s1_zhi_r;
  rrfp_pkg::frame_rec_t s1_rec_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_present_r, out_last_r;
  logic [15:0]          out_distance_r, out_energy_r;
  logic [3:0]           out_gate_r;

  logic                 out_adv, s1_adv, issue, last_issue, z_lo, z_hi;
  logic [7:0]           off_lo, off_hi;
  logic [AW-1:0]        bank_base;

  assign out_adv    = !out_valid_r || out_ready;
  assign s1_adv     = !s1_valid_r || out_adv;
  assign issue      = active_r && s1_adv;
  assign last_issue = (gate_r == GW'(GATE_COUNT - 1));
  assign pop        = !active_r && head_valid;

  // gate g takes payload bytes 3+2g and 4+2g; bytes past the store read as zero
  assign off_lo     = 8'd3 + 8'({gate_r, 1'b0});
  assign off_hi     = off_lo + 8'd1;
  assign z_lo       = (off_lo >= 8'(REPORT_BYTES));
  assign z_hi       = (off_hi >= 8'(REPORT_BYTES));
  assign bank_base  = cur_r.bank ? AW'(REPORT_BYTES) : '0;
  assign rd_addr_lo = z_lo ? bank_base : bank_base + AW'(off_lo);
  assign rd_addr_hi = z_hi ? bank_base : bank_base + AW'(off_hi);
  assign rd_en      = issue;

  // the bank is free once its last gate is read into the RAM output register
  assign free_en    = issue && last_issue;
  assign free_bank  = cur_r.bank;

  always_comb begin
    active_nxt    = active_r;
    gate_nxt      = gate_r;
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (pop) begin
      active_nxt = 1'b1;
      gate_nxt   = '0;
    end else if (issue) begin
      gate_nxt = gate_r + GW'(1);
      if (last_issue) begin
        active_nxt = 1'b0;
      end
    end
    if (s1_adv) begin
      s1_valid_nxt = issue;
    end
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      gate_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      gate_r      <= gate_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_rec;
    end
    if (issue) begin
      s1_gate_r <= gate_r;
      s1_last_r <= last_issue;
      s1_zlo_r  <= z_lo;
      s1_zhi_r  <= z_hi;
      s1_rec_r  <= cur_r;
    end
    if (out_adv && s1_valid_r) begin
      out_present_r  <= s1_rec_r.present;
      out_distance_r <= s1_rec_r.distance;
      out_gate_r     <= 4'(s1_gate_r);
      out_energy_r   <= {s1_zhi_r ? 8'h00 : rd_data_hi, s1_zlo_r ? 8'h00 : rd_data_lo};
      out_last_r     <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_present     = out_present_r;
  assign out_distance    = out_distance_r;
  assign out_gate_index  = out_gate_r;
  assign out_gate_energy = out_energy_r;
  assign out_last        = out_last_r;

endmodule

FILE: src/radar_report_frame_parser_core.sv
// Top level of the radar report frame parser: parser, frame queue, payload RAM, readout.
// Depends on rrfp_pkg, assert_macros.svh, rrfp_front, rrfp_queue, rrfp_ram, rrfp_back.
//
//   channel  dir  tdata fields (low bit up)                         tlast
//   in_      in   rx_byte[7:0]                                      -
//   out_     out  target_present, target_range, gate_index,          last_gate
//                 gate_energy, 3 zero bits
//
// One byte is taken per cycle. in_tready drops only while the payload bank the
// parser writes next still waits to be read out; the two banks let one frame be
// parsed while the previous one is read. A report frame yields GATE_COUNT results,
// one per cycle while out_tready is high, via the frame queue, readout start, RAM
// read and output register. Reset is synchronous; the payload RAM needs no clearing
// pass. out_tready low holds the output register and the read stage behind it.
`include "assert_macros.svh"

module radar_report_frame_parser_core #(
  parameter int FRAME_LIMIT  = rrfp_pkg::FRAME_LIMIT_DEF,
  parameter int REPORT_BYTES = rrfp_pkg::REPORT_BYTES_DEF,
  parameter int GATE_COUNT   = rrfp_pkg::GATE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] target_present, [16:1] target_range,
                                  // [20:17] gate_index, [36:21] gate_energy, [39:37] zero
  output logic        out_tlast   // last_gate
);

  localparam int AW = $clog2(2 * REPORT_BYTES);
  localparam logic [3:0] LAST_IDX = 4'(GATE_COUNT - 1);

  logic                 wr_en, push, pop, head_valid, free_en, free_bank, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr_lo, rd_addr_hi;
  logic [7:0]           wr_data, rd_data_lo, rd_data_hi;
  logic [1:0]           busy, q_count;
  rrfp_pkg::frame_rec_t push_rec, head_rec;
  logic                 o_present;
  logic [15:0]          o_distance, o_energy;
  logic [3:0]           o_gate;

  rrfp_front #(
    .FRAME_LIMIT  (FRAME_LIMIT),
    .REPORT_BYTES (REPORT_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_rec  (push_rec),
    .free_en   (free_en),
    .free_bank (free_bank),
    .busy      (busy)
  );

  rrfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .count      (q_count)
  );

  rrfp_ram #(
    .WIDTH (8),
    .DEPTH (2 * REPORT_BYTES)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .re      (rd_en),
    .raddr_a (rd_addr_lo),
    .raddr_b (rd_addr_hi),
    .rdata_a (rd_data_lo),
    .rdata_b (rd_data_hi)
  );

  rrfp_back #(
    .REPORT_BYTES (REPORT_BYTES),
    .GATE_COUNT   (GATE_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_rec        (head_rec),
    .pop             (pop),
    .free_en         (free_en),
    .free_bank       (free_bank),
    .rd_en           (rd_en),
    .rd_addr_lo      (rd_addr_lo),
    .rd_addr_hi      (rd_addr_hi),
    .rd_data_lo      (rd_data_lo),
    .rd_data_hi      (rd_data_hi),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_present     (o_present),
    .out_distance    (o_distance),
    .out_gate_index  (o_gate),
    .out_gate_energy (o_energy),
    .out_last        (out_tlast)
  );

  assign out_tdata = {3'b000, o_energy, o_gate, o_distance, o_present};

  // every queued frame owns a bank until its readout is done
  `RRFP_ASSERT(a_queue_le_busy, 32'(q_count) <= $countones(busy), "queue holds unowned frame")
  `RRFP_ASSERT_IMPL(a_push_free_bank, push, !busy[push_rec.bank], "push into a busy bank")
  `RRFP_ASSERT_IMPL(a_free_owned, free_en, busy[free_bank], "release of an idle bank")
  `RRFP_ASSERT_IMPL(a_last_index, out_tvalid && out_tlast, o_gate == LAST_IDX, "last gate index")

endmodule

FILE: test/radar_report_frame_parser_core_test.sv
// Self-checking bench for radar_report_frame_parser_core: byte stream in, gate reports out.
// Depends on rrfp_pkg and the RTL under src; predicts every report from the accepted bytes.
`timescale 1ns / 100ps

module radar_report_frame_parser_core_test;

  localparam int FRAME_LIMIT  = rrfp_pkg::FRAME_LIMIT_DEF;
  localparam int REPORT_BYTES = rrfp_pkg::REPORT_BYTES_DEF;
  localparam int GATE_COUNT   = rrfp_pkg::GATE_COUNT_DEF;
  localparam int MAX_SHOWN    = 10;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEM_TARGET  = 330;

  typedef enum int { FILL_ZERO, FILL_ONES, FILL_RANDOM } fill_t;
  localparam int NO_FAULT = -1;

  typedef struct {
    logic        present;
    logic [15:0] distance;
    logic [3:0]  index;
    logic [15:0] energy;
    logic        last_gate;
  } gate_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [0] present, [16:1] distance, [20:17] gate,
                                  // [36:21] energy, [39:37] zero
  logic        out_tlast;

  radar_report_frame_parser_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Stimulus and expectation stores
  logic [7:0]   rx_byte_q[$];
  gate_report_t gate_report_q[$];
  int unsigned  bytes_total = 0;
  int unsigned  bytes_taken = 0;
  int unsigned  mismatch_cnt = 0;

  // Deframer state
  int unsigned  frm_pos = 0;
  logic [15:0]  frm_len = '0;
  logic         tail_good = 1'b1;
  logic [7:0]   pay_mem[REPORT_BYTES];

  logic [7:0] hdr_seq[4]  = '{rrfp_pkg::HDR_B0, rrfp_pkg::HDR_B1,
                              rrfp_pkg::HDR_B2, rrfp_pkg::HDR_B3};
  logic [7:0] tail_seq[4] = '{rrfp_pkg::TAIL_B0, rrfp_pkg::TAIL_B1,
                              rrfp_pkg::TAIL_B2, rrfp_pkg::TAIL_B3};

  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [7:0] pay_at(input int unsigned idx);
    return (idx < REPORT_BYTES) ? pay_mem[idx] : 8'h00;
  endfunction

  // Advance the deframer by one accepted byte and queue any reports it completes
  task automatic parse_rx_byte(input logic [7:0] b);
    int unsigned  pos_now;
    int unsigned  tpos;
    gate_report_t rep;
    if (frm_pos < 4) begin
      if (b != hdr_seq[frm_pos]) begin
        frm_pos = (frm_pos == 1 && b == rrfp_pkg::HDR_B0) ? 1 : 0;
        tail_good = 1'b1;
      end else begin
        frm_pos++;
      end
      return;
    end
    pos_now = frm_pos;
    frm_pos++;
    if (pos_now == 4) begin
      frm_len = {8'h00, b};
      return;
    end
    if (pos_now == 5) begin
      frm_len[15:8] = b;
      if (10 + int'(frm_len) > FRAME_LIMIT) begin
        frm_pos = 0;
        tail_good = 1'b1;
      end
      return;
    end
    if (pos_now < 6 + int'(frm_len)) begin
      if (pos_now - 6 < REPORT_BYTES) pay_mem[pos_now - 6] = b;
    end else begin
      tpos = pos_now - 6 - int'(frm_len);
      if (tpos < 4 && b != tail_seq[tpos]) tail_good = 1'b0;
    end
    if (frm_pos < 10 + int'(frm_len)) return;
    if (tail_good && frm_len == REPORT_BYTES) begin
      for (int g = 0; g < GATE_COUNT; g++) begin
        rep.present   = (pay_at(0) != 8'h00);
        rep.distance  = {pay_at(2), pay_at(1)};
        rep.index     = g[3:0];
        rep.energy    = {pay_at(4 + 2 * g), pay_at(3 + 2 * g)};
        rep.last_gate = (g == GATE_COUNT - 1);
        gate_report_q.push_back(rep);
      end
    end
    frm_pos = 0;
    tail_good = 1'b1;
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_byte_q.push_back(b);
    bytes_total++;
  endtask

  // Queue one frame; an oversized length stops after the length bytes
  task automatic push_frame(input int unsigned len, input fill_t fill, input int tail_fault);
    logic [15:0] len16;
    len16 = len[15:0];
    for (int i = 0; i < 4; i++) push_byte(hdr_seq[i]);
    push_byte(len16[7:0]);
    push_byte(len16[15:8]);
    if (10 + len > FRAME_LIMIT) return;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: push_byte(8'h00);
        FILL_ONES: push_byte(8'hFF);
        default:   push_byte(8'($urandom_range(0, 255)));
      endcase
    end
    for (int i = 0; i < 4; i++) begin
      if (i == tail_fault) push_byte(tail_seq[i] ^ 8'($urandom_range(1, 255)));
      else push_byte(tail_seq[i]);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN)
      $display("mismatch on %s at %0t: expected %0h, got %0h", field, $realtime, want, got);
  endtask

  // Driver: one byte per transfer, random gap after each one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        parse_rx_byte(in_tdata);
        bytes_taken++;
      end
      if (in_gap != 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (rx_byte_q.size() != 0) begin
        in_tdata <= rx_byte_q.pop_front();
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 6);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each report transfer with the oldest prediction
  always @(posedge clk) begin
    gate_report_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (gate_report_q.size() == 0) begin
          report_mismatch("unexpected report", 16'h0, out_tdata[36:21]);
        end else begin
          want = gate_report_q.pop_front();
          if (out_tdata[0] !== want.present)
            report_mismatch("target_present", 16'(want.present), 16'(out_tdata[0]));
          if (out_tdata[16:1] !== want.distance)
            report_mismatch("target_range", want.distance, out_tdata[16:1]);
          if (out_tdata[20:17] !== want.index)
            report_mismatch("gate_index", 16'(want.index), 16'(out_tdata[20:17]));
          if (out_tdata[36:21] !== want.energy)
            report_mismatch("gate_energy", want.energy, out_tdata[36:21]);
          if (out_tdata[39:37] !== 3'b000)
            report_mismatch("tdata padding", 16'h0, 16'(out_tdata[39:37]));
          if (out_tlast !== want.last_gate)
            report_mismatch("last_gate", 16'(want.last_gate), 16'(out_tlast));
        end
        if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
        out_hold = out_burst ? 0 : $urandom_range(0, 6);
      end else if (out_hold != 0) begin
        out_hold--;
      end
      out_tready <= (out_hold == 0);
    end
  end

  initial begin
    int unsigned good_frames;
    int unsigned pick;
    int unsigned cnt;

    // Header hunt: non-F4 after F4, mismatch at third and fourth byte
    push_byte(rrfp_pkg::HDR_B0); push_byte(8'h00);
    push_byte(rrfp_pkg::HDR_B0); push_byte(rrfp_pkg::HDR_B1); push_byte(8'hF3);
    push_byte(rrfp_pkg::HDR_B0); push_byte(rrfp_pkg::HDR_B1);
    push_byte(rrfp_pkg::HDR_B2); push_byte(rrfp_pkg::HDR_B0);
    // F4 F4 resumes at the second header byte
    push_byte(rrfp_pkg::HDR_B0);
    push_frame(REPORT_BYTES, FILL_ZERO, NO_FAULT);
    push_frame(REPORT_BYTES, FILL_ONES, NO_FAULT);
    // Oversized lengths, low byte and high byte
    push_frame(FRAME_LIMIT - 9, FILL_RANDOM, NO_FAULT);
    push_frame(16'hFFFF, FILL_RANDOM, NO_FAULT);
    // Empty payload parses but never reports
    push_frame(0, FILL_RANDOM, NO_FAULT);
    // Trailer fault at every position
    for (int i = 0; i < 4; i++) push_frame(REPORT_BYTES, FILL_RANDOM, i);

    // Random part: mostly report frames, the rest broken frames and noise
    good_frames = 0;
    while (bytes_total < ITEM_TARGET || good_frames < 1) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        push_frame(REPORT_BYTES, FILL_RANDOM, NO_FAULT);
        good_frames++;
      end else if (pick < 68) begin
        push_frame($urandom_range(0, REPORT_BYTES + 5), FILL_RANDOM, NO_FAULT);
      end else if (pick < 76) begin
        push_frame(REPORT_BYTES, FILL_RANDOM, $urandom_range(0, 3));
      end else if (pick < 82) begin
        push_frame($urandom_range(FRAME_LIMIT - 9, 16'hFFFF), FILL_RANDOM, NO_FAULT);
      end else if (pick < 92) begin
        // noise that never looks like a header byte
        cnt = $urandom_range(1, 5);
        repeat (cnt) push_byte(8'($urandom_range(0, 8'hEF)));
      end else begin
        // partial header, then drop back to the hunt
        cnt = $urandom_range(1, 3);
        for (int i = 0; i < cnt; i++) push_byte(hdr_seq[i]);
        push_byte(8'($urandom_range(0, 8'hEF)));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken != bytes_total) @(posedge clk);
    while (gate_report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
